### hdl/fol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency-ordered list package
// Shared constants, the table entry type, opcodes and cell commands.
// ----------------------------------------------------------------------------
package fol_pkg;

    // Table geometry.
    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 16;

    // Port field widths.
    localparam int KEY_W  = 16;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 16;
    localparam int USED_W = 5;

    // Derived internal widths.
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int USED_CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_ST_W   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    // Saturation value shared by the entry counts and the access counter.
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_ACCESS = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    // One table entry as held by a cell.
    typedef struct packed {
        logic [KEY_ST_W-1:0] key;
        logic [CNT_W-1:0]    count;
        logic [CNT_W-1:0]    first;
        logic                accessed;
    } t_entry;

    // Per-cell update command.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SHIFT = 2'd2
    } t_cell_cmd;

endpackage

### hdl/frequency_ordered_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency-ordered list unit
// Self-organizing key table kept in order of access count, built as a row
// of cells that each hold one entry and shift into their back neighbor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid with i_opcode, i_key and i_position; a transfer
//   takes place on a rising edge with i_in_valid high and o_in_stall low.
//   Opcodes append a key at the tail, access a key (count, then reorder) or
//   read the entry at a position; the fourth code does nothing.
//   Output channel: o_out_valid with the result fields; a transfer takes
//   place on a rising edge with o_out_valid high and i_out_stall low.
//   Every input transfer gives exactly one output transfer.
//   Steps: the lookup compare, the select of the hit entry with its count
//   update, and the parallel compare and shift of the cell row, in turn;
//   the result is then registered. A new item is taken only once the last
//   one has left the move step.
//   A waiting result does not block the next input transfer; the cell row
//   is updated only when the output register is free, so a stalled receiver
//   holds the block in its last step with the table untouched.
//   Reset (i_rst_n low, synchronous) empties the table, clears the access
//   counter and drops any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
module frequency_ordered_list_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [fol_pkg::KEY_W-1:0]   i_key,
    input  logic [fol_pkg::POS_W-1:0]   i_position,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic                        o_error,
    output logic [fol_pkg::POS_W-1:0]   o_result_position,
    output logic [fol_pkg::KEY_W-1:0]   o_result_key,
    output logic [fol_pkg::CNT_W-1:0]   o_result_count,
    output logic [fol_pkg::USED_W-1:0]  o_entries_used
);
    import fol_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FIND = 2'd1,
        S_MOVE = 2'd2
    } t_state;

    t_state                r_state;
    t_opcode               r_op;
    logic [KEY_ST_W-1:0]   r_key;
    logic [POS_W-1:0]      r_pos;
    logic [ENTRIES-1:0]    r_match;
    t_entry                r_sel;
    logic [IDX_W-1:0]      r_sel_idx;
    logic                  r_sel_ok;
    logic [USED_CNT_W-1:0] r_used;
    logic [CNT_W-1:0]      r_counter;
    logic                  r_out_valid;
    logic                  r_hit;
    logic                  r_error;
    logic [POS_W-1:0]      r_res_pos;
    logic [KEY_W-1:0]      r_res_key;
    logic [CNT_W-1:0]      r_res_count;

    logic [KEY_ST_W-1:0]   w_key_in;
    t_entry                w_entry  [ENTRIES];
    t_cell_cmd             w_cmd    [ENTRIES];
    logic [ENTRIES-1:0]    w_match;
    logic [ENTRIES-1:0]    w_beaten;
    logic [ENTRIES-1:0]    w_live;
    t_entry                w_zero_entry;

    logic                  w_accept;
    logic [ENTRIES-1:0]    w_first;
    t_entry                w_hit_entry;
    logic [IDX_W-1:0]      w_hit_idx;
    t_entry                w_rd_entry;
    logic                  w_rd_ok;
    t_entry                n_sel;
    logic [IDX_W-1:0]      n_sel_idx;
    logic                  n_sel_ok;

    logic [IDX_W-1:0]      w_dest;
    logic [IDX_W-1:0]      w_load_idx;
    logic                  w_commit;
    logic                  w_write;
    logic [USED_CNT_W-1:0] n_used;

    assign w_key_in     = i_key[KEY_ST_W-1:0];
    assign w_zero_entry = '0;
    assign o_in_stall   = (r_state != S_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;

    // Row of cells; each one takes its front neighbor's entry on a shift.
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        t_entry w_prev;
        if (k == 0) begin : g_head
            assign w_prev = w_zero_entry;
        end else begin : g_body
            assign w_prev = w_entry[k-1];
        end

        assign w_live[k] = (r_used > USED_CNT_W'(k));

        fol_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (w_cmd[k]),
            .i_new    (r_sel),
            .i_prev   (w_prev),
            .i_key    (w_key_in),
            .o_entry  (w_entry[k]),
            .o_match  (w_match[k]),
            .o_beaten (w_beaten[k])
        );
    end

    // Lookup step: first matching entry from the front, and the read entry.
    always_comb begin
        w_first     = r_match & (~r_match + 1'b1);
        w_hit_entry = '0;
        w_hit_idx   = '0;
        w_rd_entry  = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (w_first[k]) begin
                w_hit_entry = w_hit_entry | w_entry[k];
                w_hit_idx   = w_hit_idx | IDX_W'(k);
            end
            if (int'(r_pos) == k) begin
                w_rd_entry = w_entry[k];
            end
        end
        w_rd_ok = (int'(r_pos) < int'(r_used)) && (int'(r_pos) < ENTRIES);
    end

    // Entry that the last step writes or reports, with its updated count.
    always_comb begin
        n_sel     = '0;
        n_sel_idx = '0;
        n_sel_ok  = 1'b0;
        unique case (r_op)
            OP_APPEND: begin
                n_sel.key = r_key;
                n_sel_idx = IDX_W'(r_used);
                n_sel_ok  = (int'(r_used) < ENTRIES);
            end
            OP_ACCESS: begin
                n_sel          = w_hit_entry;
                n_sel.count    = (w_hit_entry.count != COUNT_MAX) ?
                                 w_hit_entry.count + 1'b1 : w_hit_entry.count;
                n_sel.first    = w_hit_entry.accessed ? w_hit_entry.first : r_counter;
                n_sel.accessed = 1'b1;
                n_sel_idx      = w_hit_idx;
                n_sel_ok       = |r_match;
            end
            OP_READ: begin
                n_sel     = w_rd_entry;
                n_sel_idx = IDX_W'(r_pos);
                n_sel_ok  = w_rd_ok;
            end
            OP_NONE: begin
                n_sel_ok = 1'b0;
            end
        endcase
    end

    // Move step: an accessed entry settles just behind the last entry it cannot pass.
    always_comb begin
        w_dest = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if ((IDX_W'(k) < r_sel_idx) && !w_beaten[k]) begin
                w_dest = IDX_W'(k + 1);
            end
        end
        w_load_idx = (r_op == OP_ACCESS) ? w_dest : r_sel_idx;
    end

    assign w_commit = (r_state == S_MOVE) && (!r_out_valid || !i_out_stall);
    assign w_write  = w_commit && r_sel_ok && ((r_op == OP_APPEND) || (r_op == OP_ACCESS));
    assign n_used   = r_used + USED_CNT_W'((r_op == OP_APPEND) && r_sel_ok);

    // Cell commands: load at the destination, shift the passed entries back.
    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            if (!w_write) begin
                w_cmd[k] = CELL_HOLD;
            end else if (IDX_W'(k) == w_load_idx) begin
                w_cmd[k] = CELL_LOAD;
            end else if ((r_op == OP_ACCESS) && (IDX_W'(k) > w_load_idx) &&
                         (IDX_W'(k) <= r_sel_idx)) begin
                w_cmd[k] = CELL_SHIFT;
            end else begin
                w_cmd[k] = CELL_HOLD;
            end
        end
    end

    // Operation registers, captured without reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_opcode'(i_opcode);
            r_key   <= w_key_in;
            r_pos   <= i_position;
            r_match <= w_match & w_live;
        end
        if (r_state == S_FIND) begin
            r_sel     <= n_sel;
            r_sel_idx <= n_sel_idx;
            r_sel_ok  <= n_sel_ok;
        end
    end

    // Sequencer, table occupancy, access counter and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    if (w_commit) begin
                        r_state     <= S_IDLE;
                        r_used      <= n_used;
                        r_out_valid <= 1'b1;
                        if ((r_op == OP_ACCESS) && r_sel_ok && (r_counter != COUNT_MAX)) begin
                            r_counter <= r_counter + 1'b1;
                        end
                        r_hit       <= r_sel_ok && ((r_op == OP_ACCESS) || (r_op == OP_READ));
                        r_error     <= (r_op == OP_APPEND) && !r_sel_ok;
                        r_res_pos   <= r_sel_ok ? POS_W'(w_load_idx) : '0;
                        r_res_key   <= r_sel_ok ? KEY_W'(r_sel.key) : '0;
                        r_res_count <= r_sel_ok ? r_sel.count : '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_hit;
    assign o_error           = r_error;
    assign o_result_position = r_res_pos;
    assign o_result_key      = r_res_key;
    assign o_result_count    = r_res_count;
    assign o_entries_used    = USED_W'(r_used);

endmodule

### hdl/fol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency-ordered list cell
// Holds one table entry, compares it against the incoming key and the moving
// entry, and loads either a new entry or the entry of its front neighbor.
// ----------------------------------------------------------------------------
module fol_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fol_pkg::t_cell_cmd            i_cmd,
    input  fol_pkg::t_entry               i_new,
    input  fol_pkg::t_entry               i_prev,
    input  logic [fol_pkg::KEY_ST_W-1:0]  i_key,
    output fol_pkg::t_entry               o_entry,
    output logic                          o_match,
    output logic                          o_beaten
);
    import fol_pkg::*;

    logic [KEY_ST_W-1:0] r_key;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_first;
    logic                r_accessed;
    t_entry              n_entry;

    // Next entry: load the new one, take the neighbor's, or keep.
    always_comb begin
        n_entry = o_entry;
        unique case (i_cmd)
            CELL_LOAD:  n_entry = i_new;
            CELL_SHIFT: n_entry = i_prev;
            CELL_HOLD:  n_entry = o_entry;
            default:    n_entry = o_entry;
        endcase
    end

    // The accessed flag is cleared at reset; the payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accessed <= 1'b0;
        end else begin
            r_accessed <= n_entry.accessed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_entry.key;
        r_count <= n_entry.count;
        r_first <= n_entry.first;
    end

    assign o_entry = '{key: r_key, count: r_count, first: r_first, accessed: r_accessed};

    // Key compare for the lookup.
    assign o_match = (r_key == i_key);

    // The moving entry passes this one on a higher count, or on an equal
    // count with an earlier first access when both have been accessed.
    assign o_beaten = (i_new.count > r_count) ||
                      ((i_new.count == r_count) && r_accessed && i_new.accessed &&
                       (i_new.first < r_first));

endmodule

### hdl/fol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency-ordered list checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module fol_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_hit,
    input logic                        o_error,
    input logic [fol_pkg::POS_W-1:0]   o_result_position,
    input logic [fol_pkg::KEY_W-1:0]   o_result_key,
    input logic [fol_pkg::CNT_W-1:0]   o_result_count,
    input logic [fol_pkg::USED_W-1:0]  o_entries_used
);
    import fol_pkg::*;

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_result_key) && $stable(o_result_count) &&
            $stable(o_result_position))
        else $error("stalled result changed or dropped");

    // A result never reports both a hit and a rejected append.
    a_hit_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_error))
        else $error("hit and error both set");

    // A hit always points inside the used part of the table.
    a_hit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> (USED_W'(o_result_position) < o_entries_used))
        else $error("hit position beyond used entries");

    // A rejected append only happens on a full table and reports no entry.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |->
            (o_entries_used == USED_W'(ENTRIES)) && (o_result_count == '0) &&
            (o_result_key == '0))
        else $error("append rejected on a table that is not full");

    // The block is busy in the cycle after it takes an item.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again without processing");

endmodule

bind frequency_ordered_list_unit fol_checker u_fol_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_hit             (o_hit),
    .o_error           (o_error),
    .o_result_position (o_result_position),
    .o_result_key      (o_result_key),
    .o_result_count    (o_result_count),
    .o_entries_used    (o_entries_used)
);

### verif/frequency_ordered_list_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency-ordered list unit testbench
// Drives opcodes through the input channel and checks every result against
// a fixed expectation or a behavioral model of the table that tracks keys,
// counts, first-access stamps and the reordering. A directed table covers
// the empty table, the key extremes, repeated accesses of one key and the
// full table. Random traffic follows, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module frequency_ordered_list_unit_tb;

    import fol_pkg::*;

    localparam int LIMIT_CYCLES    = 4_000_000;
    localparam int SAT_RUN         = 20;
    localparam int RANDOM_ITEMS    = 1900;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 10;

    // One entry of the modeled table.
    typedef struct {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] first;
        bit               accessed;
    } t_list_entry;

    // One result transfer, all fields.
    typedef struct packed {
        logic              hit;
        logic              error;
        logic [POS_W-1:0]  pos;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
        logic [USED_W-1:0] used;
    } t_list_result;

    // One row of the directed table; a row may repeat with a key step.
    typedef struct {
        t_opcode          op;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        bit               typed;
        t_list_result     want;
        int               reps;
        logic [KEY_W-1:0] step;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic [KEY_W-1:0]   i_key;
    logic [POS_W-1:0]   i_position;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_hit;
    logic               o_error;
    logic [POS_W-1:0]   o_result_position;
    logic [KEY_W-1:0]   o_result_key;
    logic [CNT_W-1:0]   o_result_count;
    logic [USED_W-1:0]  o_entries_used;

    // Modeled table state.
    t_list_entry        tbl [ENTRIES];
    logic [USED_W-1:0]  tbl_used;
    logic [CNT_W-1:0]   access_clock;

    t_list_result       pending_results [$];
    t_stim_row          stim_rows [$];
    int                 mismatch_cnt;
    int                 burst_left;
    int                 cycle_cnt;
    bit                 hold_off_req;
    bit                 hold_off_done;

    frequency_ordered_list_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_key             (i_key),
        .i_position        (i_position),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hit             (o_hit),
        .o_error           (o_error),
        .o_result_position (o_result_position),
        .o_result_key      (o_result_key),
        .o_result_count    (o_result_count),
        .o_entries_used    (o_entries_used)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one operation to the modeled table and returns its result.
    function automatic t_list_result table_apply(t_opcode op, logic [KEY_W-1:0] k,
                                                 logic [POS_W-1:0] p);
        t_list_result r;
        t_list_entry  tmp;
        int           at;
        r  = '0;
        at = -1;
        case (op)
            OP_APPEND: begin
                if (tbl_used >= ENTRIES) begin
                    r.error = 1'b1;
                end else begin
                    tbl[tbl_used].key      = k;
                    tbl[tbl_used].count    = '0;
                    tbl[tbl_used].first    = '0;
                    tbl[tbl_used].accessed = 1'b0;
                    r.pos    = tbl_used[POS_W-1:0];
                    r.key    = k;
                    tbl_used = tbl_used + 1'b1;
                end
            end
            OP_ACCESS: begin
                // The first match from the front wins.
                for (int j = 0; j < int'(tbl_used); j++) begin
                    if (at < 0 && tbl[j].key == k) at = j;
                end
                if (at >= 0) begin
                    if (tbl[at].count != COUNT_MAX) tbl[at].count = tbl[at].count + 1'b1;
                    if (!tbl[at].accessed) begin
                        tbl[at].accessed = 1'b1;
                        tbl[at].first    = access_clock;
                    end
                    if (access_clock != COUNT_MAX) access_clock = access_clock + 1'b1;
                    // Bubble forward past lower counts, or equal counts first seen later.
                    while (at > 0 && (tbl[at].count > tbl[at-1].count ||
                           (tbl[at].count == tbl[at-1].count && tbl[at].accessed &&
                            tbl[at-1].accessed && tbl[at].first < tbl[at-1].first))) begin
                        tmp       = tbl[at];
                        tbl[at]   = tbl[at-1];
                        tbl[at-1] = tmp;
                        at--;
                    end
                    r.hit   = 1'b1;
                    r.pos   = POS_W'(at);
                    r.key   = tbl[at].key;
                    r.count = tbl[at].count;
                end
            end
            OP_READ: begin
                if (p < tbl_used) begin
                    r.hit   = 1'b1;
                    r.pos   = p;
                    r.key   = tbl[p].key;
                    r.count = tbl[p].count;
                end
            end
            default: begin
            end
        endcase
        r.used = tbl_used;
        return r;
    endfunction

    function automatic t_list_result outcome(bit h, bit e, int p, int k, int c, int u);
        t_list_result r;
        r.hit   = h;
        r.error = e;
        r.pos   = POS_W'(p);
        r.key   = KEY_W'(k);
        r.count = CNT_W'(c);
        r.used  = USED_W'(u);
        return r;
    endfunction

    function automatic string fmt_result(t_list_result r);
        return $sformatf("hit=%0d error=%0d pos=%0d key=%h count=%0d used=%0d",
                         r.hit, r.error, r.pos, r.key, r.count, r.used);
    endfunction

    function automatic void add_row(t_opcode op, logic [KEY_W-1:0] k, logic [POS_W-1:0] p,
                                    bit typed = 1'b0, t_list_result want = '0,
                                    int reps = 1, logic [KEY_W-1:0] step = '0);
        t_stim_row row;
        row.op    = op;
        row.key   = k;
        row.pos   = p;
        row.typed = typed;
        row.want  = want;
        row.reps  = reps;
        row.step  = step;
        stim_rows.push_back(row);
    endfunction

    // Offers one item in bursts with random gaps and records its expected result.
    task automatic send_item(t_opcode op, logic [KEY_W-1:0] k, logic [POS_W-1:0] p,
                             bit typed, t_list_result want);
        t_list_result pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            repeat ($urandom_range(0, 6)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_key      <= k;
        i_position <= p;
        do @(posedge i_clk); while (o_in_stall);
        pred = table_apply(op, k, p);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Receiver stall pattern, with one long hold-off to fill the block.
    initial begin : out_stall_gen
        int seg_len;
        int stall_pct;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                for (int c = 0; c < HOLD_OFF_CYCLES; c++) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
                hold_off_done = 1'b1;
            end
            seg_len = $urandom_range(1, 60);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (seg_len) begin
                @(negedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Result checker: each output transfer against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        t_list_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.hit   = o_hit;
            got.error = o_error;
            got.pos   = o_result_position;
            got.key   = o_result_key;
            got.count = o_result_count;
            got.used  = o_entries_used;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("[%0t] unexpected result: %s", $realtime, fmt_result(got));
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.error !== want.error ||
                    got.pos !== want.pos || got.key !== want.key ||
                    got.count !== want.count || got.used !== want.used) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: expected %s", $realtime, fmt_result(want));
                        $display("[%0t]           actual   %s", $realtime, fmt_result(got));
                    end
                end
            end
        end
    end

    // Watchdog on the cycle count.
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("** frequency_ordered_list_unit: FAILED **");
        $finish;
    end

    // Stimulus: reset, directed table, then random traffic.
    initial begin : stimulus
        t_stim_row        row;
        t_opcode          op;
        logic [KEY_W-1:0] k;
        logic [POS_W-1:0] p;
        int               sel;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_NONE;
        i_key         = '0;
        i_position    = '0;
        tbl_used      = '0;
        access_clock  = '0;
        mismatch_cnt  = 0;
        burst_left    = 0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        for (int j = 0; j < ENTRIES; j++) tbl[j] = '{default: '0};

        // Empty table, then a few entries with reordering.
        add_row(OP_READ,   16'h0000, 4'd0,  1'b1, outcome(0, 0, 0, 0, 0, 0));
        add_row(OP_ACCESS, 16'hFFFF, 4'd15, 1'b1, outcome(0, 0, 0, 0, 0, 0));
        add_row(OP_NONE,   16'hFFFF, 4'd15, 1'b1, outcome(0, 0, 0, 0, 0, 0));
        add_row(OP_APPEND, 16'h0000, 4'd0,  1'b1, outcome(0, 0, 0, 16'h0000, 0, 1));
        add_row(OP_APPEND, 16'hFFFF, 4'd15, 1'b1, outcome(0, 0, 1, 16'hFFFF, 0, 2));
        add_row(OP_APPEND, 16'hA5A5, 4'd5,  1'b1, outcome(0, 0, 2, 16'hA5A5, 0, 3));
        add_row(OP_APPEND, 16'h5A5A, 4'd10, 1'b1, outcome(0, 0, 3, 16'h5A5A, 0, 4));
        add_row(OP_ACCESS, 16'hFFFF, 4'd0);
        add_row(OP_ACCESS, 16'h5A5A, 4'd0);
        add_row(OP_ACCESS, 16'h5A5A, 4'd0);
        add_row(OP_READ,   16'h0000, 4'd15, 1'b1, outcome(0, 0, 0, 0, 0, 4));
        add_row(OP_READ,   16'h0000, 4'd3);
        add_row(OP_APPEND, 16'h0000, 4'd0,  1'b1, outcome(0, 0, 4, 16'h0000, 0, 5));
        add_row(OP_ACCESS, 16'h0000, 4'd0);
        add_row(OP_ACCESS, 16'h1234, 4'd0,  1'b1, outcome(0, 0, 0, 0, 0, 5));
        // A run of accesses on one key moves it to the front.
        add_row(OP_ACCESS, 16'h0000, 4'd0,  1'b0, '0, SAT_RUN);
        add_row(OP_READ,   16'h0000, 4'd0);
        // Fill the table, overflow it, and reorder entries near the tail.
        add_row(OP_APPEND, 16'h8000, 4'd0,  1'b0, '0, 10, 16'd1);
        add_row(OP_APPEND, 16'h7FFF, 4'd0,  1'b1, outcome(0, 0, 15, 16'h7FFF, 0, 16));
        add_row(OP_APPEND, 16'h1111, 4'd0,  1'b1, outcome(0, 1, 0, 0, 0, 16));
        add_row(OP_ACCESS, 16'h8003, 4'd0);
        add_row(OP_ACCESS, 16'h8007, 4'd0);
        add_row(OP_ACCESS, 16'h7FFF, 4'd0);
        add_row(OP_READ,   16'h0000, 4'd15);
        add_row(OP_NONE,   16'h0000, 4'd0,  1'b1, outcome(0, 0, 0, 0, 0, 16));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        foreach (stim_rows[n]) begin
            row = stim_rows[n];
            for (int r = 0; r < row.reps; r++)
                send_item(row.op, row.key + KEY_W'(r) * row.step, row.pos, row.typed, row.want);
        end

        // Random traffic, mostly accesses of keys held in the table.
        hold_off_req = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            k   = KEY_W'($urandom);
            p   = POS_W'($urandom);
            if (sel < 55 && tbl_used != 0) begin
                op = OP_ACCESS;
                k  = tbl[$urandom_range(0, int'(tbl_used) - 1)].key;
            end else if (sel < 65) begin
                op = OP_ACCESS;
            end else if (sel < 82) begin
                op = OP_READ;
            end else if (sel < 93) begin
                op = OP_APPEND;
            end else begin
                op = OP_NONE;
            end
            send_item(op, k, p, 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain the outstanding results, then watch for strays.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("** frequency_ordered_list_unit: PASSED **");
        end else begin
            $display("** frequency_ordered_list_unit: FAILED **");
        end
        $finish;
    end

endmodule
